// File: rtl/tbrs_pkg.sv
// Shared types and constants of the token bucket receive shaper.
// No dependencies; tbrs_refill and the top level import this package.
package tbrs_pkg;

  localparam int RATE_W  = 24;
  localparam int LIMIT_W = 8;
  localparam int NOW_W   = 48;
  localparam int REQ_W   = 7;
  localparam int KIND_W  = 2;
  localparam int REG_IDX_W = 1;

  localparam longint unsigned US_PER_S = 64'd1000000;

  localparam logic [LIMIT_W-1:0] OVF_LIMIT_RESET = 8'd8;
  localparam logic [LIMIT_W-1:0] OVF_COUNT_MAX   = 8'hFF;

  localparam logic MODE_INGEST = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_INGEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_BYTE_RATE      = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_OVERFLOW_LIMIT = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFILL,
    ST_CALC,
    ST_DRAIN
  } tbrs_state_t;

  typedef enum logic [2:0] {
    RF_IDLE,
    RF_MUL,
    RF_SUM,
    RF_CHECK,
    RF_DIV,
    RF_DONE
  } tbrs_rf_state_t;

endpackage

// File: rtl/tbrs_byte_ram.sv
// Byte store of the shaper: one write port and one read port, read data
// registered. Depends on nothing but its parameters.
module tbrs_byte_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/tbrs_refill.sv
// Refill unit: tokens earned = elapsed time * byte_rate / 1e6, capped at the
// buffer size. Two-part multiply, then a reciprocal multiply. Uses tbrs_pkg.
module tbrs_refill #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [tbrs_pkg::NOW_W-1:0]   elapsed,
  input  logic [tbrs_pkg::RATE_W-1:0]  rate,
  output logic                         done,
  output logic [$clog2(BUFFER_BYTES+1)-1:0] add
);
  import tbrs_pkg::*;

  localparam int PTR_W  = $clog2(BUFFER_BYTES);
  localparam int CNT_W  = $clog2(BUFFER_BYTES+1);
  localparam longint unsigned CAP = longint'(BUFFER_BYTES) * US_PER_S;
  localparam int ELAP_W = $clog2(CAP + 1);
  localparam int HALF_W = RATE_W / 2;
  localparam int PART_W = ELAP_W + HALF_W;
  localparam int PROD_W = ELAP_W + RATE_W;

  // One million is 2^6 * 15625. Below the cap the product shifted right by six
  // has at most 26 bits, and 2^44 / 15625 rounded up divides all of them exactly.
  localparam int DIV_SHIFT   = 6;
  localparam int Q_W         = ELAP_W - DIV_SHIFT;
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 44;
  localparam logic [RECIP_W-1:0] RECIP_M = 31'd1125899907;
  localparam int RP_W        = Q_W + RECIP_W;

  tbrs_rf_state_t state, state_next;

  logic [ELAP_W-1:0] elap;
  logic [RATE_W-1:0] rate_r;
  logic [PART_W-1:0] p_lo, p_hi;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  add_r;
  logic [RP_W-1:0]   recip_prod;

  assign recip_prod = RP_W'(prod[ELAP_W-1:DIV_SHIFT]) * RP_W'(RECIP_M);

  always_comb begin
    state_next = state;
    case (state)
      RF_IDLE:  if (go) state_next = RF_MUL;
      RF_MUL:   state_next = RF_SUM;
      RF_SUM:   state_next = RF_CHECK;
      RF_CHECK: state_next = (prod >= PROD_W'(CAP)) ? RF_DONE : RF_DIV;
      RF_DIV:   state_next = RF_DONE;
      RF_DONE:  state_next = RF_IDLE;
      default:  state_next = RF_IDLE;
    endcase
  end

  always_comb begin
    done = (state == RF_DONE);
    add  = add_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RF_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      RF_IDLE: begin
        // Beyond the cap the bucket fills completely, so a clamp loses nothing.
        if (elapsed > NOW_W'(CAP)) begin
          elap <= ELAP_W'(CAP);
        end else begin
          elap <= elapsed[ELAP_W-1:0];
        end
        rate_r <= rate;
      end
      RF_MUL: begin
        p_lo <= PART_W'(elap) * PART_W'(rate_r[HALF_W-1:0]);
        p_hi <= PART_W'(elap) * PART_W'(rate_r[RATE_W-1:HALF_W]);
      end
      RF_SUM: begin
        prod <= PROD_W'(p_lo) + (PROD_W'(p_hi) << HALF_W);
      end
      RF_CHECK: begin
        add_r <= CNT_W'(BUFFER_BYTES);
      end
      RF_DIV: begin
        add_r <= CNT_W'(recip_prod[RECIP_SHIFT +: PTR_W]);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/token_bucket_receive_shaper_unit.sv
// Top level of the token bucket receive shaper: control, state registers,
// result registers. Uses tbrs_pkg, tbrs_byte_ram and tbrs_refill.
//
// An ingest word does not raise busy, so ingest words may arrive every cycle
// while no read holds busy high; each gives one result word in the following
// cycle. A read request holds busy high while the read is sized and its bytes
// are drained one after another, each shown for one cycle on result_strobe.
// With pacing on, the bucket seeded and time advanced, the refill unit runs
// before the sizing: a two-step multiply, a cap check and, when the earned
// tokens stay below the cap, a reciprocal multiply for the divide by one
// million. The receiver cannot stall; every result is taken as shown.
// Configuration writes take effect at once and must fall while busy is low.
module token_bucket_receive_shaper_unit #(
  parameter int BUFFER_BYTES = 4096,
  parameter int MAX_READ     = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode,
  input  logic [7:0]                        data_byte,
  input  logic                              end_of_datagram,
  input  logic [tbrs_pkg::REQ_W-1:0]        read_limit,
  input  logic [tbrs_pkg::NOW_W-1:0]        now_us,
  input  logic                              wr_en,
  input  logic [tbrs_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [tbrs_pkg::RATE_W-1:0]       wr_data,
  output logic                              result_strobe,
  output logic [tbrs_pkg::KIND_W-1:0]       kind,
  output logic [7:0]                        out_byte,
  output logic                              last,
  output logic [tbrs_pkg::LIMIT_W-1:0]      overflow_count,
  output logic                              fault
);
  import tbrs_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W = $clog2(BUFFER_BYTES+1);
  localparam int N_W   = $clog2(MAX_READ+1);

  tbrs_state_t state, state_next;

  logic [RATE_W-1:0]  byte_rate;
  logic [LIMIT_W-1:0] overflow_limit;
  logic [PTR_W-1:0]   read_pointer;
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   token_count;
  logic [NOW_W-1:0]   last_refill_time;
  logic [LIMIT_W-1:0] overflow_counter;
  logic               datagram_dropped;
  logic               fault_flag;
  logic [N_W-1:0]     n_req;
  logic [N_W-1:0]     issue_left;
  logic               pace;
  logic               from_ram;

  logic               accept, ingest_acc, read_acc;
  logic               full, pace_now, seeded, later, rf_go, rf_done, rd_en;
  logic [CNT_W-1:0]   rf_add;
  logic [PTR_W:0]     wsum;
  logic [PTR_W-1:0]   wr_addr, rp_next;
  logic [REQ_W-1:0]   limit_clamped;
  logic [N_W-1:0]     n_req_next, n_eff;
  logic [CNT_W:0]     topped;
  logic [CNT_W-1:0]   token_next;
  logic               dropped_now, fault_next;
  logic [LIMIT_W-1:0] ovf_inc, ovf_lim, ovf_next;
  logic [7:0]         rd_data;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign ingest_acc = accept && (mode == MODE_INGEST);
  assign read_acc   = accept && (mode == MODE_READ);

  // Ingest path.
  assign full    = (fill_count == CNT_W'(BUFFER_BYTES));
  assign wsum    = (PTR_W+1)'(read_pointer) + (PTR_W+1)'(fill_count[PTR_W-1:0]);
  assign wr_addr = (wsum >= (PTR_W+1)'(BUFFER_BYTES))
                   ? PTR_W'(wsum - (PTR_W+1)'(BUFFER_BYTES)) : wsum[PTR_W-1:0];

  assign dropped_now = datagram_dropped || full;
  assign ovf_inc     = (overflow_counter == OVF_COUNT_MAX) ? overflow_counter
                                                          : overflow_counter + 1'b1;
  assign ovf_lim     = (overflow_limit == '0) ? LIMIT_W'(1) : overflow_limit;

  always_comb begin
    ovf_next   = overflow_counter;
    fault_next = fault_flag;
    if (end_of_datagram) begin
      if (dropped_now) begin
        ovf_next = ovf_inc;
        if (ovf_inc >= ovf_lim) begin
          fault_next = 1'b1;
        end
      end else begin
        ovf_next = '0;
      end
    end
  end

  // Read sizing.
  assign limit_clamped = (read_limit > REQ_W'(MAX_READ)) ? REQ_W'(MAX_READ) : read_limit;
  assign n_req_next    = (32'(limit_clamped) < 32'(fill_count))
                         ? N_W'(limit_clamped) : N_W'(fill_count);
  assign pace_now      = (byte_rate != '0);
  assign seeded        = (last_refill_time != '0);
  assign later         = (now_us > last_refill_time);
  assign n_eff         = (pace && (32'(token_count) < 32'(n_req)))
                         ? N_W'(token_count) : n_req;

  assign topped     = (CNT_W+1)'(token_count) + (CNT_W+1)'(rf_add);
  assign token_next = (topped > (CNT_W+1)'(BUFFER_BYTES))
                      ? CNT_W'(BUFFER_BYTES) : topped[CNT_W-1:0];

  assign rp_next = (read_pointer == PTR_W'(BUFFER_BYTES-1)) ? '0 : read_pointer + 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (read_acc) begin
          state_next = rf_go ? ST_REFILL : ST_CALC;
        end
      end
      ST_REFILL: if (rf_done) state_next = ST_CALC;
      ST_CALC:   state_next = (n_eff == '0) ? ST_IDLE : ST_DRAIN;
      ST_DRAIN:  if (issue_left == N_W'(1)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    rf_go = 1'b0;
    rd_en = 1'b0;
    case (state)
      ST_IDLE:  rf_go = read_acc && pace_now && seeded && later;
      ST_DRAIN: rd_en = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      byte_rate        <= '0;
      overflow_limit   <= OVF_LIMIT_RESET;
      read_pointer     <= '0;
      fill_count       <= '0;
      token_count      <= '0;
      last_refill_time <= '0;
      overflow_counter <= '0;
      datagram_dropped <= 1'b0;
      fault_flag       <= 1'b0;
      result_strobe    <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= 1'b0;
      if (wr_en) begin
        case (wr_index)
          REG_BYTE_RATE:      byte_rate      <= wr_data;
          REG_OVERFLOW_LIMIT: overflow_limit <= wr_data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (ingest_acc) begin
            if (!full) begin
              fill_count <= fill_count + 1'b1;
            end
            datagram_dropped <= end_of_datagram ? 1'b0 : dropped_now;
            overflow_counter <= ovf_next;
            fault_flag       <= fault_next;
            result_strobe    <= 1'b1;
          end
          // The first timestamp only seeds the bucket; time going backwards
          // leaves it untouched.
          if (read_acc && pace_now && (!seeded || later)) begin
            last_refill_time <= now_us;
          end
        end
        ST_REFILL: begin
          if (rf_done) begin
            token_count <= token_next;
          end
        end
        ST_CALC: begin
          if (n_eff == '0) begin
            result_strobe <= 1'b1;
          end
        end
        ST_DRAIN: begin
          read_pointer  <= rp_next;
          fill_count    <= fill_count - 1'b1;
          if (pace) begin
            token_count <= token_count - 1'b1;
          end
          result_strobe <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result payload and read bookkeeping; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n_req          <= n_req_next;
        pace           <= pace_now;
        kind           <= KIND_INGEST;
        last           <= 1'b1;
        from_ram       <= 1'b0;
        overflow_count <= ovf_next;
        fault          <= fault_next;
      end
      ST_CALC: begin
        issue_left     <= n_eff;
        kind           <= KIND_EMPTY;
        last           <= 1'b1;
        from_ram       <= 1'b0;
        overflow_count <= overflow_counter;
        fault          <= fault_flag;
      end
      ST_DRAIN: begin
        issue_left     <= issue_left - 1'b1;
        kind           <= KIND_DATA;
        last           <= (issue_left == N_W'(1));
        from_ram       <= 1'b1;
        overflow_count <= overflow_counter;
        fault          <= fault_flag;
      end
      default: begin
      end
    endcase
  end

  assign out_byte = from_ram ? rd_data : '0;

  tbrs_byte_ram #(
    .DEPTH  (BUFFER_BYTES),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ingest_acc && !full),
    .wr_addr (wr_addr),
    .wr_data (data_byte),
    .rd_en   (rd_en),
    .rd_addr (read_pointer),
    .rd_data (rd_data)
  );

  tbrs_refill #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_refill (
    .clk     (clk),
    .rst     (rst),
    .go      (rf_go),
    .elapsed (now_us - last_refill_time),
    .rate    (byte_rate),
    .done    (rf_done),
    .add     (rf_add)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(BUFFER_BYTES))
    else $error("fill count beyond buffer size");

  a_token_bound: assert property (@(posedge clk) disable iff (rst)
    token_count <= CNT_W'(BUFFER_BYTES))
    else $error("token count beyond bucket cap");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (fill_count != '0))
    else $error("drain issued from an empty buffer");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (kind != KIND_DATA)) |-> last)
    else $error("ingest or empty-read word not marked last");

endmodule
